FILE: hdl/chx_pkg.sv
// chx_pkg: shared types, codes and helper functions for the colon-hex body codec.
// No dependencies.
`default_nettype none

package chx_pkg;

    typedef enum logic [1:0] {
        MODE_ESCAPE   = 2'd0,
        MODE_UNESCAPE = 2'd1,
        MODE_ENCODE   = 2'd2,
        MODE_DECODE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_HIGH = 3'b010,
        PH_LOW  = 3'b100
    } phase_t;

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_EQUAL = 8'h3d;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;

    // One queued work unit: either a single result or a three-byte ':hh' group.
    typedef struct packed {
        logic       grp;
        logic [7:0] data;
        logic       has_byte;
        logic       malformed;
        logic       last;
    } job_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       msg_end;
        logic       malformed;
    } beat_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hexval_t;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        begin
            if (v < 4'd10) begin
                r = 8'h30 + {4'h0, v};
            end else begin
                r = 8'h57 + {4'h0, v};
            end
            return r;
        end
    endfunction

    function automatic hexval_t hex_val(input logic [7:0] c);
        hexval_t r;
        begin
            r = '0;
            if (c >= 8'h30 && c <= 8'h39) begin
                r.ok  = 1'b1;
                r.val = c[3:0];
            end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
                r.ok  = 1'b1;
                r.val = c[3:0] + 4'd9;
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hdl/chx_front.sv
// chx_front: accepts input bytes, holds the mode register and decode state,
// and turns each byte into at most one queued job. Depends on chx_pkg.
`default_nettype none

module chx_front
    import chx_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_in_last,
    input  wire logic       q_ready,
    output logic            q_push,
    output job_t            q_job
);

    mode_t      mode_reg;
    phase_t     phase_reg, phase_next;
    logic [3:0] nib_reg, nib_next;
    logic       drop_reg, drop_next;
    logic       job_valid;
    job_t       job;
    logic       accept;
    logic       strict;
    logic       special;
    hexval_t    hv;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;
    assign strict  = (mode_reg == MODE_DECODE);
    assign hv      = hex_val(s_in_byte);
    assign special = (s_in_byte == CH_COLON) || (s_in_byte == CH_EQUAL) ||
                     (s_in_byte == CH_COMMA) || (s_in_byte == CH_LF) ||
                     (s_in_byte == CH_CR);

    always_comb begin
        job            = '0;
        job.last       = s_in_last;
        job_valid      = 1'b0;
        phase_next     = phase_reg;
        nib_next       = nib_reg;
        drop_next      = drop_reg;
        unique case (mode_reg)
            MODE_ESCAPE: begin
                job_valid    = 1'b1;
                job.grp      = special;
                job.data     = s_in_byte;
                job.has_byte = 1'b1;
            end
            MODE_ENCODE: begin
                job_valid    = 1'b1;
                job.grp      = 1'b1;
                job.data     = s_in_byte;
                job.has_byte = 1'b1;
            end
            default: begin
                if (drop_reg) begin
                    job_valid     = s_in_last;
                    job.malformed = 1'b1;
                end else begin
                    unique case (phase_reg)
                        PH_IDLE: begin
                            if (s_in_byte == CH_COLON) begin
                                if (s_in_last) begin
                                    job_valid     = 1'b1;
                                    job.malformed = 1'b1;
                                    drop_next     = 1'b1;
                                end else begin
                                    phase_next = PH_HIGH;
                                end
                            end else if (strict) begin
                                job_valid     = 1'b1;
                                job.malformed = 1'b1;
                                drop_next     = 1'b1;
                            end else begin
                                job_valid    = 1'b1;
                                job.data     = s_in_byte;
                                job.has_byte = 1'b1;
                            end
                        end
                        PH_HIGH: begin
                            if (!hv.ok || s_in_last) begin
                                job_valid     = 1'b1;
                                job.malformed = 1'b1;
                                drop_next     = 1'b1;
                            end else begin
                                nib_next   = hv.val;
                                phase_next = PH_LOW;
                            end
                        end
                        default: begin
                            if (!hv.ok) begin
                                job_valid     = 1'b1;
                                job.malformed = 1'b1;
                                drop_next     = 1'b1;
                            end else begin
                                phase_next   = PH_IDLE;
                                job_valid    = 1'b1;
                                job.data     = {nib_reg, hv.val};
                                job.has_byte = 1'b1;
                            end
                        end
                    endcase
                end
            end
        endcase
        if (s_in_last) begin
            phase_next = PH_IDLE;
            nib_next   = 4'h0;
            drop_next  = 1'b0;
        end
    end

    assign q_push = accept && job_valid;
    assign q_job  = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_ESCAPE;
            phase_reg <= PH_IDLE;
            nib_reg   <= 4'h0;
            drop_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            mode_reg  <= mode_t'(cfg_wr_data);
            phase_reg <= PH_IDLE;
            nib_reg   <= 4'h0;
            drop_reg  <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            nib_reg   <= nib_next;
            drop_reg  <= drop_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/chx_fifo.sv
// chx_fifo: short job queue between front and back.
// Depends on chx_pkg (job_t).
`default_nettype none

module chx_fifo
    import chx_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      not_full,
    input  wire logic pop,
    output logic      not_empty,
    output job_t      head_job
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    job_t          mem [DEPTH];
    logic [IW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign not_full  = (count_reg != CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head_job  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/chx_back.sv
// chx_back: expands queued jobs into result beats through an output register,
// one per cycle while m_ready allows. Depends on chx_pkg.
`default_nettype none

module chx_back
    import chx_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    input  wire job_t q_job,
    output logic      q_pop,
    output logic      m_valid,
    input  wire logic m_ready,
    output beat_t     m_beat
);

    logic       out_valid_reg;
    beat_t      out_beat_reg;
    logic       act_reg;
    job_t       job_reg;
    logic [1:0] idx_reg;
    logic       adv;
    job_t       sel_job;
    logic [1:0] sel_idx;
    beat_t      beat;

    assign adv     = !out_valid_reg || m_ready;
    assign q_pop   = adv && !act_reg && q_valid;
    assign sel_job = act_reg ? job_reg : q_job;
    assign sel_idx = act_reg ? idx_reg : 2'd0;

    always_comb begin
        beat = '0;
        if (!sel_job.grp) begin
            beat.out_byte  = sel_job.data;
            beat.has_byte  = sel_job.has_byte;
            beat.malformed = sel_job.malformed;
            beat.run_last  = 1'b1;
            beat.msg_end   = sel_job.last;
        end else begin
            beat.has_byte = 1'b1;
            case (sel_idx)
                2'd0:    beat.out_byte = CH_COLON;
                2'd1:    beat.out_byte = hex_char(sel_job.data[7:4]);
                default: begin
                    beat.out_byte = hex_char(sel_job.data[3:0]);
                    beat.run_last = 1'b1;
                    beat.msg_end  = sel_job.last;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_beat_reg <= beat;
        end
        if (q_pop) begin
            job_reg <= q_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            act_reg       <= 1'b0;
            idx_reg       <= 2'd0;
        end else if (adv) begin
            if (act_reg) begin
                out_valid_reg <= 1'b1;
                if (idx_reg == 2'd2) begin
                    act_reg <= 1'b0;
                end
                idx_reg <= idx_reg + 2'd1;
            end else if (q_valid) begin
                out_valid_reg <= 1'b1;
                act_reg       <= q_job.grp;
                idx_reg       <= 2'd1;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_beat  = out_beat_reg;

endmodule

`default_nettype wire

FILE: hdl/colon_hex_body_codec.sv
// colon_hex_body_codec: top level of the colon-hex escape/encode/decode codec.
// Depends on chx_pkg, chx_front, chx_fifo, chx_back.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_in_byte, s_in_last
//   m_      | out       | m_valid / m_ready  | m_out_byte, m_has_byte, m_run_last,
//           |           |                    | m_msg_end, m_malformed
//   cfg_    | in        | cfg_wr_en          | cfg_wr_data (codec_mode)
//
// One result per cycle from the back end's output register while not stalled.
// An escaped or hex-encoded byte gives three results (':hh'), any other byte one;
// decode modes take 1 input per cycle if the FIFO has room; the back end sets the rate.
// Reset: mode escape, decode state, queue and output valid cleared.
// m_ready low holds the output; input keeps flowing until the FIFO_DEPTH queue fills.
`default_nettype none

module colon_hex_body_codec
    import chx_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_in_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_has_byte,
    output logic            m_run_last,
    output logic            m_msg_end,
    output logic            m_malformed
);

    logic  q_push, q_not_full, q_pop, q_not_empty;
    job_t  push_job, head_job;
    beat_t beat;

    chx_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .q_ready     (q_not_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    chx_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    chx_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_not_empty),
        .q_job   (head_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_beat  (beat)
    );

    assign m_out_byte  = beat.out_byte;
    assign m_has_byte  = beat.has_byte;
    assign m_run_last  = beat.run_last;
    assign m_msg_end   = beat.msg_end;
    assign m_malformed = beat.malformed;

endmodule

`default_nettype wire

FILE: hdl/chx_checker.sv
// chx_checker: port-level assertions for colon_hex_body_codec, bound to the top.
// Depends on colon_hex_body_codec ports only.
`default_nettype none

module chx_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic       m_has_byte,
    input wire logic       m_run_last,
    input wire logic       m_msg_end,
    input wire logic       m_malformed
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_msg_end))
        else $error("output transaction changed while stalled");

    a_end_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_msg_end |-> m_run_last)
        else $error("message end without run end");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_byte |-> m_malformed && m_run_last && (m_out_byte == 8'h00))
        else $error("status-only transaction not a malformed report");

    a_bad_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_malformed |-> !m_has_byte)
        else $error("malformed flag on data transaction");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind colon_hex_body_codec chx_checker u_chx_checker (.*);

`default_nettype wire

FILE: test/colon_hex_body_codec_tb.sv
`timescale 1ns / 1ps
// colon_hex_body_codec_tb: self-checking testbench for the colon-hex body codec.
// Runs directed and random messages through all four modes and predicts each result.
// Depends on chx_pkg and colon_hex_body_codec.

module colon_hex_body_codec_tb;
    import chx_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int RANDOM_ROUNDS  = 8;
    localparam int ROUND_ITEMS    = 46;

    class codec_scoreboard;
        mode_t      mode     = MODE_ESCAPE;
        phase_t     phase    = PH_IDLE;
        logic [3:0] high_dig = '0;
        bit         dropping = 1'b0;
        beat_t      pending_beats[$];
        int         errors   = 0;

        function void set_mode(mode_t m);
            mode     = m;
            phase    = PH_IDLE;
            high_dig = '0;
            dropping = 1'b0;
        endfunction

        function void push_beat(logic [7:0] data, logic has, logic bad);
            beat_t e;
            e.out_byte  = data;
            e.has_byte  = has;
            e.run_last  = 1'b0;
            e.msg_end   = 1'b0;
            e.malformed = bad;
            pending_beats.push_back(e);
        endfunction

        function logic [7:0] hex_lower(logic [3:0] v);
            if (v < 4'd10) begin
                return 8'h30 + {4'h0, v};
            end
            return 8'h61 + {4'h0, v} - 8'd10;
        endfunction

        function int digit_value(logic [7:0] c);
            if (c >= "0" && c <= "9") begin
                return int'(c) - int'("0");
            end
            if (c >= "a" && c <= "f") begin
                return int'(c) - int'("a") + 10;
            end
            if (c >= "A" && c <= "F") begin
                return int'(c) - int'("A") + 10;
            end
            return -1;
        endfunction

        function void push_group(logic [7:0] data);
            push_beat(CH_COLON, 1'b1, 1'b0);
            push_beat(hex_lower(data[7:4]), 1'b1, 1'b0);
            push_beat(hex_lower(data[3:0]), 1'b1, 1'b0);
        endfunction

        function void flag_malformed();
            dropping = 1'b1;
            push_beat(8'h00, 1'b0, 1'b1);
        endfunction

        function void decode(logic [7:0] data, logic last, bit strict);
            int d;
            d = digit_value(data);
            if (dropping) begin
                if (last) begin
                    push_beat(8'h00, 1'b0, 1'b1);
                end
                return;
            end
            case (phase)
                PH_IDLE: begin
                    if (data == CH_COLON) begin
                        if (last) flag_malformed();
                        else phase = PH_HIGH;
                    end else if (strict) begin
                        flag_malformed();
                    end else begin
                        push_beat(data, 1'b1, 1'b0);
                    end
                end
                PH_HIGH: begin
                    if (d < 0 || last) begin
                        flag_malformed();
                    end else begin
                        high_dig = d[3:0];
                        phase    = PH_LOW;
                    end
                end
                default: begin
                    if (d < 0) begin
                        flag_malformed();
                    end else begin
                        phase = PH_IDLE;
                        push_beat({high_dig, d[3:0]}, 1'b1, 1'b0);
                    end
                end
            endcase
        endfunction

        function void note_input(logic [7:0] data, logic last);
            int    count_before;
            beat_t e;
            count_before = pending_beats.size();
            case (mode)
                MODE_ESCAPE: begin
                    if (data == CH_COLON || data == CH_EQUAL || data == CH_COMMA ||
                        data == CH_LF || data == CH_CR) begin
                        push_group(data);
                    end else begin
                        push_beat(data, 1'b1, 1'b0);
                    end
                end
                MODE_UNESCAPE: decode(data, last, 1'b0);
                MODE_ENCODE:   push_group(data);
                default:       decode(data, last, 1'b1);
            endcase
            if (pending_beats.size() > count_before) begin
                e = pending_beats.pop_back();
                e.run_last = 1'b1;
                e.msg_end  = last;
                pending_beats.push_back(e);
            end
            if (last) begin
                phase    = PH_IDLE;
                high_dig = '0;
                dropping = 1'b0;
            end
        endfunction

        function void check_result(beat_t got);
            beat_t e;
            if (pending_beats.size() == 0) begin
                $error("unexpected result: out_byte %h has_byte %b run_last %b msg_end %b malformed %b",
                       got.out_byte, got.has_byte, got.run_last, got.msg_end, got.malformed);
                errors++;
                return;
            end
            e = pending_beats.pop_front();
            if (got.out_byte !== e.out_byte) begin
                $error("out_byte: expected %h, got %h", e.out_byte, got.out_byte);
                errors++;
            end
            if (got.has_byte !== e.has_byte) begin
                $error("has_byte: expected %b, got %b", e.has_byte, got.has_byte);
                errors++;
            end
            if (got.run_last !== e.run_last) begin
                $error("run_last: expected %b, got %b", e.run_last, got.run_last);
                errors++;
            end
            if (got.msg_end !== e.msg_end) begin
                $error("msg_end: expected %b, got %b", e.msg_end, got.msg_end);
                errors++;
            end
            if (got.malformed !== e.malformed) begin
                $error("malformed: expected %b, got %b", e.malformed, got.malformed);
                errors++;
            end
        endfunction
    endclass

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [1:0] cfg_wr_data = '0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte   = '0;
    logic       s_in_last   = 1'b0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_has_byte;
    logic       m_run_last;
    logic       m_msg_end;
    logic       m_malformed;

    codec_scoreboard sb;
    bit src_idle     = 1'b1;
    bit snk_idle     = 1'b1;
    int quiet_cycles = 0;

    colon_hex_body_codec u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_has_byte  (m_has_byte),
        .m_run_last  (m_run_last),
        .m_msg_end   (m_msg_end),
        .m_malformed (m_malformed)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic logic [7:0] digit_char(logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + {4'h0, v};
        end
        if ($urandom_range(0, 1) == 1) begin
            return 8'h41 + {4'h0, v} - 8'd10;
        end
        return 8'h61 + {4'h0, v} - 8'd10;
    endfunction

    task automatic send_item(input logic [7:0] data, input logic last);
        int gap;
        gap = src_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_in_byte = data;
        s_in_last = last;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_input(data, last);
        @(negedge aclk);
    endtask

    // drain, let groups still in flight settle, then write the mode
    task automatic write_mode(input mode_t m);
        s_valid = 1'b0;
        while (sb.pending_beats.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = m;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.set_mode(m);
    endtask

    task automatic send_random_message(input mode_t m, output int sent);
        logic [7:0] msg[$];
        logic [7:0] v;
        int         len, k, kind, drop_n;
        len = $urandom_range(1, 12);
        for (k = 0; k < len; k++) begin
            kind = $urandom_range(0, 19);
            v    = $urandom_range(0, 255);
            if (m == MODE_ESCAPE || m == MODE_ENCODE) begin
                if (kind < 7) begin
                    case (kind % 5)
                        0: v = CH_COLON;
                        1: v = CH_EQUAL;
                        2: v = CH_COMMA;
                        3: v = CH_LF;
                        default: v = CH_CR;
                    endcase
                end
                msg.push_back(v);
            end else if (kind == 19) begin
                msg.push_back(v);
            end else if (m == MODE_UNESCAPE && kind < 6) begin
                if (v == CH_COLON) v = 8'h3b;
                msg.push_back(v);
            end else begin
                msg.push_back(CH_COLON);
                msg.push_back(digit_char(v[7:4]));
                msg.push_back(digit_char(v[3:0]));
            end
        end
        if (m == MODE_UNESCAPE || m == MODE_DECODE) begin
            if ($urandom_range(0, 9) == 0) begin
                msg[$urandom_range(0, msg.size() - 1)] = $urandom_range(0, 255);
            end
            if ($urandom_range(0, 9) == 0 && msg.size() > 2) begin
                drop_n = $urandom_range(1, 2);
                repeat (drop_n) void'(msg.pop_back());
            end
        end
        for (k = 0; k < msg.size(); k++) begin
            send_item(msg[k], k == msg.size() - 1);
        end
        sent = msg.size();
    endtask

    // sink: random backpressure per transaction
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = snk_idle ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            sb.check_result({m_out_byte, m_has_byte, m_run_last, m_msg_end, m_malformed});
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        mode_t round_modes[RANDOM_ROUNDS];
        int    r, round_count, sent;
        round_modes = '{MODE_DECODE, MODE_UNESCAPE, MODE_ENCODE, MODE_ESCAPE,
                        MODE_UNESCAPE, MODE_DECODE, MODE_ESCAPE, MODE_ENCODE};
        sb = new;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_mode(MODE_ESCAPE);
        send_item(CH_COLON, 1'b0);
        send_item(CH_EQUAL, 1'b0);
        send_item(CH_COMMA, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(CH_CR, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b1);

        write_mode(MODE_ENCODE);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b1);

        write_mode(MODE_UNESCAPE);
        send_item(CH_COLON, 1'b0);
        send_item("F", 1'b0);
        send_item("f", 1'b0);
        send_item("x", 1'b0);
        send_item(CH_COLON, 1'b0);
        send_item("g", 1'b0);      // bad digit, rest dropped
        send_item("q", 1'b1);
        send_item(CH_COLON, 1'b1); // colon cut off by end of message
        send_item(CH_COLON, 1'b0);
        send_item("4", 1'b1);      // group cut off after high digit
        send_item(CH_COLON, 1'b0); // open group abandoned by mode write

        write_mode(MODE_DECODE);
        send_item(CH_COLON, 1'b0);
        send_item("0", 1'b0);
        send_item("0", 1'b1);
        send_item("a", 1'b1);      // no colon at group start

        for (r = 0; r < RANDOM_ROUNDS; r++) begin
            write_mode(round_modes[r]);
            src_idle    = (r % 3 != 2);
            snk_idle    = (r % 4 != 1);
            round_count = 0;
            while (round_count < ROUND_ITEMS) begin
                send_random_message(round_modes[r], sent);
                round_count += sent;
            end
        end

        s_valid = 1'b0;
        while (sb.pending_beats.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/chx_pkg.sv
hdl/chx_front.sv
hdl/chx_fifo.sv
hdl/chx_back.sv
hdl/colon_hex_body_codec.sv
hdl/chx_checker.sv
test/colon_hex_body_codec_tb.sv
